/* rtl/tdcp_pkg.sv */
// -----------------------------------------------------------------------------
// Text display control parser package
// Shared codes, the write plan type and the position command helper.
// -----------------------------------------------------------------------------
package tdcp_pkg;

   // Default number of character cells in one display row.
   localparam int ROW_WIDTH_DEFAULT = 16;

   // Display command codes.
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_POS   = 8'h80;

   // Received character codes with special meaning.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LINE  = 8'h11;
   localparam logic [7:0] CH_COL   = 8'h12;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Leading writes of one received byte; the run of spaces travels beside it.
   typedef struct packed {
      logic       head_valid;
      logic       head_is_data;
      logic [7:0] head_byte;
      logic       mid_valid;
      logic [7:0] mid_byte;
   } plan_type;

   // Position command for a line and column, kept to eight bits.
   function automatic logic [7:0] pos_byte(input logic [7:0] line, input logic [7:0] col);
      pos_byte = CMD_POS | {line[2:0], 5'b0} | col;
   endfunction

endpackage

/* rtl/tdcp_decode.sv */
// -----------------------------------------------------------------------------
// Text display control parser decoder
// Holds the parser state and turns one byte into a plan of display writes.
// -----------------------------------------------------------------------------
module tdcp_decode
   import tdcp_pkg::*;
#(
   parameter int ROW_WIDTH = ROW_WIDTH_DEFAULT,
   parameter int SPACE_W   = $clog2(ROW_WIDTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         rx_byte,
   input  logic               take,
   output plan_type           plan,
   output logic [SPACE_W-1:0] plan_spaces
);

   logic [7:0] prev_ff, prev_in;
   logic       esc_ff, esc_in;
   logic [7:0] line_ff, line_in;
   logic [7:0] col_ff, col_in;

   // Escape pairs first, then the ordinary character rules.
   always_comb begin
      prev_in     = rx_byte;
      esc_in      = 1'b0;
      line_in     = line_ff;
      col_in      = col_ff;
      plan        = '0;
      plan_spaces = '0;
      if (!esc_ff && prev_ff == CH_NUL && rx_byte == CH_NUL) begin
         line_in         = 8'h00;
         col_in          = 8'h00;
         esc_in          = 1'b1;
         plan.head_valid = 1'b1;
         plan.head_byte  = CMD_CLEAR;
         plan.mid_valid  = 1'b1;
         plan.mid_byte   = pos_byte(8'h00, 8'h00);
      end else if (!esc_ff && prev_ff == CH_LINE) begin
         line_in         = rx_byte;
         col_in          = 8'h00;
         esc_in          = 1'b1;
         plan.head_valid = 1'b1;
         plan.head_byte  = pos_byte(rx_byte, 8'h00);
      end else if (!esc_ff && prev_ff == CH_COL) begin
         col_in          = rx_byte;
         esc_in          = 1'b1;
         plan.head_valid = 1'b1;
         plan.head_byte  = pos_byte(line_ff, rx_byte);
      end else if (rx_byte == CH_CR || rx_byte == CH_NUL) begin
         plan.head_valid = 1'b1;
         plan.head_byte  = pos_byte(line_ff, col_ff);
         if (col_ff < 8'(ROW_WIDTH)) begin
            plan_spaces = SPACE_W'(9'(ROW_WIDTH) - {1'b0, col_ff});
         end
      end else if (rx_byte == CH_LINE || rx_byte == CH_COL) begin
         // An escape opener writes nothing until its argument arrives.
         plan.head_valid = 1'b0;
      end else if (rx_byte == CH_LF) begin
         if (prev_ff == CH_CR && line_ff == 8'h00) begin
            line_in         = 8'h01;
            col_in          = 8'h00;
            plan.head_valid = 1'b1;
            plan.head_byte  = pos_byte(8'h01, 8'h00);
         end
      end else begin
         col_in            = col_ff + 8'h01;
         plan.head_valid   = 1'b1;
         plan.head_is_data = 1'b1;
         plan.head_byte    = rx_byte;
      end
   end

   // Parser state advances once per byte handed to the emitter.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 8'h00;
         esc_ff  <= 1'b0;
         line_ff <= 8'h00;
         col_ff  <= 8'h00;
      end else if (take) begin
         prev_ff <= prev_in;
         esc_ff  <= esc_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

/* rtl/tdcp_emit.sv */
// -----------------------------------------------------------------------------
// Text display control parser emitter
// Result register that plays out a plan's writes, one per cycle unless stalled.
// -----------------------------------------------------------------------------
module tdcp_emit
   import tdcp_pkg::*;
#(
   parameter int ROW_WIDTH = ROW_WIDTH_DEFAULT,
   parameter int SPACE_W   = $clog2(ROW_WIDTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               plan_valid,
   input  plan_type           plan,
   input  logic [SPACE_W-1:0] plan_spaces,
   output logic               load_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               data_ff, data_in;
   logic               last_ff, last_in;
   logic               mid_ff, mid_in;
   logic [7:0]         mid_byte_ff, mid_byte_in;
   logic [SPACE_W-1:0] spaces_ff, spaces_in;
   logic               out_free;
   logic               pend_any;

   assign out_free   = !valid_ff || rsp_tready;
   assign pend_any   = mid_ff || (spaces_ff != '0);
   assign load_ready = out_free && !pend_any;

   // Pending writes go out before a new plan is taken.
   always_comb begin
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      data_in     = data_ff;
      last_in     = last_ff;
      mid_in      = mid_ff;
      mid_byte_in = mid_byte_ff;
      spaces_in   = spaces_ff;
      if (out_free) begin
         priority if (mid_ff) begin
            valid_in = 1'b1;
            data_in  = 1'b0;
            byte_in  = mid_byte_ff;
            last_in  = (spaces_ff == '0);
            mid_in   = 1'b0;
         end else if (spaces_ff != '0) begin
            valid_in  = 1'b1;
            data_in   = 1'b1;
            byte_in   = CH_SPACE;
            last_in   = (spaces_ff == SPACE_W'(1));
            spaces_in = spaces_ff - SPACE_W'(1);
         end else if (plan_valid) begin
            valid_in    = plan.head_valid;
            data_in     = plan.head_is_data;
            byte_in     = plan.head_byte;
            last_in     = !plan.mid_valid && (plan_spaces == '0);
            mid_in      = plan.mid_valid;
            mid_byte_in = plan.mid_byte;
            spaces_in   = plan_spaces;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         mid_ff    <= 1'b0;
         spaces_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         mid_ff    <= mid_in;
         spaces_ff <= spaces_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      mid_byte_ff <= mid_byte_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/text_display_control_parser_unit.sv */
// -----------------------------------------------------------------------------
// Text display control parser unit
// Turns received serial bytes into character display command and data writes.
// -----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one received byte per transfer. The rsp_ channel
// gives the display writes it causes: rsp_tuser is 1 for a character and 0
// for a command, rsp_tlast marks the final write of that byte. A byte that
// causes no write produces no transfer at all.
// A byte goes into an input register, is decoded combinationally from it,
// and its first write is registered in the result register. Writes then
// leave one per cycle unless rsp_tready is low; most bytes cause one write,
// a blank-line run up to ROW_WIDTH + 1, and the single write slot of the
// result register keeps the next byte waiting until the last of these leaves.
// When rsp_tready is low the result register holds its write, the input
// register still takes one more byte, and req_tready then drops until the
// pending writes drain. Reset clears line, column, previous byte and the
// escape flag to zero and empties both registers.
// -----------------------------------------------------------------------------
module text_display_control_parser_unit
   import tdcp_pkg::*;
#(
   parameter int ROW_WIDTH = ROW_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] is_data
   output logic       rsp_tlast
);

   localparam int SPACE_W = $clog2(ROW_WIDTH + 1);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               load_ready;
   logic               take;
   plan_type           plan;
   logic [SPACE_W-1:0] plan_spaces;

   assign take       = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || load_ready;

   // Input register: refilled whenever its byte moves on.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   tdcp_decode #(
      .ROW_WIDTH (ROW_WIDTH),
      .SPACE_W   (SPACE_W)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (in_byte_ff),
      .take        (take),
      .plan        (plan),
      .plan_spaces (plan_spaces)
   );

   tdcp_emit #(
      .ROW_WIDTH (ROW_WIDTH),
      .SPACE_W   (SPACE_W)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .plan_valid  (in_valid_ff),
      .plan        (plan),
      .plan_spaces (plan_spaces),
      .load_ready  (load_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Text display control parser testbench
// Feeds received bytes into the parser and checks each display write against a
// cycle-free predictor of line, column and escape state (hand-written writes
// for typed rows). A short directed list comes first, then random sequences of
// escape pairs, line ends and characters, with random stalls on both sides.
// -----------------------------------------------------------------------------
module testbench;
   import tdcp_pkg::*;

   localparam int ROW_W = ROW_WIDTH_DEFAULT;

   // One display write as it leaves the block.
   typedef struct packed {
      logic       is_data;
      logic [7:0] value;
      logic       last;
   } display_write_type;

   // One stimulus byte; typed rows carry up to two writes written out by hand.
   typedef struct packed {
      logic [7:0]        rx;
      logic              typed;
      logic [1:0]        n;
      display_write_type w0;
      display_write_type w1;
   } stim_row_type;

   localparam display_write_type NO_WRITE = '0;

   // Directed bytes: extremes, every escape pair and every line-end rule.
   localparam stim_row_type DIRECTED [25] = '{
      '{CH_NUL,   1'b1, 2'd2, '{1'b0, CMD_CLEAR, 1'b0}, '{1'b0, CMD_POS, 1'b1}},
      '{CH_NUL,   1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{8'h41,    1'b1, 2'd1, '{1'b1, 8'h41, 1'b1}, NO_WRITE},
      '{8'hFF,    1'b1, 2'd1, '{1'b1, 8'hFF, 1'b1}, NO_WRITE},
      '{CH_LINE,  1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{8'hFF,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_COL,   1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{8'hFF,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{8'h42,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_CR,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_LINE,  1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_NUL,   1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_NUL,   1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_CR,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_LF,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_LF,    1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_COL,   1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{8'h10,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_CR,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_COL,   1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_CR,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_LF,    1'b1, 2'd0, NO_WRITE, NO_WRITE},
      '{8'h7F,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{8'h80,    1'b0, 2'd0, NO_WRITE, NO_WRITE},
      '{CH_NUL,   1'b0, 2'd0, NO_WRITE, NO_WRITE}
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] out_byte
   logic       rsp_tuser;    // [0] is_data
   logic       rsp_tlast;

   // Predicted parser state.
   logic [7:0] last_rx     = '0;
   logic       escape_used = 1'b0;
   logic [7:0] cur_line    = '0;
   logic [7:0] cur_col     = '0;

   display_write_type pending_writes [$];
   display_write_type model_writes [$];
   stim_row_type      byte_checks [$];
   display_write_type want;
   stim_row_type      taken_row;
   int                bytes_taken = 0;
   int                errors      = 0;
   logic              quiet_phase;

   // Neither side idles while this window of bytes goes through.
   assign quiet_phase = (bytes_taken >= 110) && (bytes_taken < 170);

   text_display_control_parser_unit #(
      .ROW_WIDTH (ROW_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Position command for the predicted line and column, cut to eight bits.
   function automatic logic [7:0] position_cmd();
      logic [12:0] p;
      p = {5'b0, CMD_POS} | {cur_line, 5'b0} | {5'b0, cur_col};
      return p[7:0];
   endfunction

   // Works out the writes one received byte causes and advances the state.
   function automatic void decode_rx_byte(input logic [7:0] rx,
                                          ref display_write_type wq[$]);
      // Escape pairs only count when the previous byte was not an argument.
      if (!escape_used) begin
         if (last_rx == CH_NUL) begin
            if (rx == CH_NUL) begin
               wq.push_back('{1'b0, CMD_CLEAR, 1'b0});
               cur_line = '0;
               cur_col  = '0;
               wq.push_back('{1'b0, position_cmd(), 1'b0});
               escape_used = 1'b1;
            end
         end else if (last_rx == CH_LINE) begin
            cur_line = rx;
            cur_col  = '0;
            wq.push_back('{1'b0, position_cmd(), 1'b0});
            escape_used = 1'b1;
         end else if (last_rx == CH_COL) begin
            cur_col = rx;
            wq.push_back('{1'b0, position_cmd(), 1'b0});
            escape_used = 1'b1;
         end
      end else begin
         escape_used = 1'b0;
      end

      // Ordinary handling of the byte.
      if (!escape_used) begin
         if (rx == CH_CR || rx == CH_NUL) begin
            wq.push_back('{1'b0, position_cmd(), 1'b0});
            for (int k = int'(cur_col); k < ROW_W; k++)
               wq.push_back('{1'b1, CH_SPACE, 1'b0});
         end else if (rx == CH_LINE || rx == CH_COL) begin
            // An escape opener writes nothing until its argument arrives.
         end else if (rx == CH_LF) begin
            if (last_rx == CH_CR && cur_line == 8'd0) begin
               cur_line = 8'd1;
               cur_col  = '0;
               wq.push_back('{1'b0, position_cmd(), 1'b0});
            end
         end else begin
            wq.push_back('{1'b1, rx, 1'b0});
            cur_col = cur_col + 8'd1;
         end
      end

      last_rx = rx;
      if (wq.size() > 0)
         wq[wq.size() - 1].last = 1'b1;
   endfunction

   // Result checking and prediction, both on accepted transfers.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: write with none outstanding: expected none, actual %b %h %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_tuser !== want.is_data) begin
               $display("%0t: is_data expected %b actual %b", $time, want.is_data, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== want.value) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.value, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         taken_row = byte_checks.pop_front();
         model_writes.delete();
         decode_rx_byte(req_tdata, model_writes);
         if (taken_row.typed) begin
            if (taken_row.n > 2'd0)
               pending_writes.push_back(taken_row.w0);
            if (taken_row.n > 2'd1)
               pending_writes.push_back(taken_row.w1);
         end else begin
            foreach (model_writes[m])
               pending_writes.push_back(model_writes[m]);
         end
         bytes_taken++;
      end
   end

   // Offers one byte, with random idle cycles ahead of it, until it is taken.
   task automatic send_byte(input stim_row_type r);
      byte_checks.push_back(r);
      while (!quiet_phase && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r.rx;
      do @(posedge clock); while (!req_tready);
   endtask

   // Receiver: random stalls, one long hold-off that backs up the input.
   initial begin : result_side
      int hold_left;
      bit held;
      hold_left  = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && bytes_taken >= 60) begin
            held      = 1'b1;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= quiet_phase || ($urandom_range(99) >= 26);
         end
      end
   end

   // Sender: reset, directed bytes, random sequences, then drain and report.
   initial begin : byte_source
      logic [7:0]   burst [$];
      stim_row_type rnd_row;
      int           sel;
      int           sent;
      bit           drained;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      sent       = 0;
      drained    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r])
         send_byte(DIRECTED[r]);

      // Mostly well-formed sequences with random content, some raw bytes.
      while (sent < 225) begin
         burst.delete();
         sel = $urandom_range(99);
         if (sel < 45) begin
            burst.push_back(8'($urandom_range(8'h7E, 8'h21)));
         end else if (sel < 55) begin
            burst.push_back(CH_LINE);
            burst.push_back($urandom_range(3) != 0 ? 8'($urandom_range(3))
                                                   : 8'($urandom_range(255)));
         end else if (sel < 65) begin
            burst.push_back(CH_COL);
            burst.push_back($urandom_range(3) != 0 ? 8'($urandom_range(20))
                                                   : 8'($urandom_range(255)));
         end else if (sel < 72) begin
            burst.push_back(CH_CR);
            burst.push_back(CH_LF);
         end else if (sel < 77) begin
            burst.push_back(CH_CR);
         end else if (sel < 80) begin
            burst.push_back(CH_NUL);
            burst.push_back(CH_NUL);
         end else if (sel < 83) begin
            burst.push_back(CH_NUL);
         end else begin
            burst.push_back(8'($urandom_range(255)));
         end
         foreach (burst[b]) begin
            rnd_row    = '0;
            rnd_row.rx = burst[b];
            send_byte(rnd_row);
         end
         sent += burst.size();

         // Once, hold the input back until every write has come out.
         if (!drained && sent >= 200) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_writes.size() != 0) @(posedge clock);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // Waiting on the clock first lets the checker book the last byte's writes.
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Run limit far above the slowest correct run.
   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
